// ----- rtl/core/tssr_pkg.sv -----
`default_nettype none
package tssr_pkg;

  localparam int unsigned PadW      = 8;
  localparam int unsigned SumW      = 10;
  localparam int unsigned DividendW = 15;
  localparam int unsigned DivisorW  = SumW;
  localparam int unsigned DivCntW   = $clog2(DividendW);
  localparam int unsigned PosW      = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [PadW-1:0] TouchLevelReset    = 8'd1;
  localparam logic [PadW-1:0] SwipeDistanceReset = 8'd40;

  localparam logic [CfgIdxW-1:0] CfgTouchLevel    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSwipeDistance = 8'd1;

  typedef enum logic [2:0] {
    GestNone     = 3'd0,
    GestPress    = 3'd1,
    GestRelease  = 3'd2,
    GestForward  = 3'd3,
    GestBackward = 3'd4
  } tssr_gesture_e;

  typedef struct packed {
    logic [PadW-1:0] pad_left;
    logic [PadW-1:0] pad_middle;
    logic [PadW-1:0] pad_right;
  } tssr_in_t;

  typedef struct packed {
    tssr_gesture_e         gesture;
    logic                  touched;
    logic signed [PosW-1:0] position;
  } tssr_out_t;

endpackage
`default_nettype wire

// ----- rtl/core/tssr_div.sv -----
`default_nettype none
module tssr_div
  import tssr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      valid_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DividendW - 1);

  logic                 busy_q, busy_d;
  logic                 valid_q, valid_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [DivisorW-1:0]  div_q, div_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      valid_d = 1'b0;
      cnt_d   = '0;
      div_d   = divisor_i;
      rem_d   = '0;
      quo_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign valid_o    = valid_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/touch_strip_swipe_recognizer_core.sv -----
`default_nettype none
// Touch strip swipe recognizer. Each sample of three pad intensities yields one
// result: the centroid position (right - left) * 100 / (left + middle + right),
// truncated toward zero and 0 for an all-zero sample, a touched flag (largest
// pad at or above touch_level), and a gesture from the idle / touched / swiping
// tracker: press, release, or swipe forward / backward once the position moves
// more than swipe_distance from where the touch began. From acceptance to result,
// the scaled difference and the sum are formed at acceptance and loaded into
// the one-bit-per-cycle restoring divider; when it is done the quotient is
// handed over to the hold state, which resolves the gesture into the result
// register. The input stalls from acceptance until the result is registered.
// The result register lets the next sample in while an earlier result still
// waits; that sample then holds after its division until the result register
// frees. Register 0 is touch_level, register 1 is swipe_distance; other
// indexes are ignored. Write registers only while idle.
module touch_strip_swipe_recognizer_core
  import tssr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tssr_in_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tssr_out_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StHold = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    PhIdle    = 3'b001,
    PhTouched = 3'b010,
    PhSwiping = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [PadW-1:0]        touch_level_q, swipe_distance_q;
  logic signed [PosW-1:0] start_q, start_d;
  logic                   neg_q, zero_q, touched_q;
  logic                   out_valid_q, out_valid_d;
  tssr_out_t              out_data_q, out_data_d;

  logic                   accept;
  logic                   emit;
  logic [SumW-1:0]        sum;
  logic [PadW-1:0]        mag;
  logic [DividendW-1:0]   scaled;
  logic [PadW-1:0]        max_lm, max_all;
  logic                   div_valid;
  logic [DividendW-1:0]   div_quo;
  logic signed [PosW-1:0] pos;
  logic signed [PosW-1:0] quo_s;
  logic signed [PosW:0]   delta, reach;
  tssr_gesture_e          gesture;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  assign sum = SumW'(in_data_i.pad_left) + SumW'(in_data_i.pad_middle)
             + SumW'(in_data_i.pad_right);
  assign mag = (in_data_i.pad_left > in_data_i.pad_right)
             ? in_data_i.pad_left - in_data_i.pad_right
             : in_data_i.pad_right - in_data_i.pad_left;
  assign scaled = {1'b0, mag, 6'b0} + {2'b0, mag, 5'b0} + {5'b0, mag, 2'b0};

  assign max_lm  = (in_data_i.pad_middle > in_data_i.pad_left)
                 ? in_data_i.pad_middle : in_data_i.pad_left;
  assign max_all = (in_data_i.pad_right > max_lm) ? in_data_i.pad_right : max_lm;

  tssr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (scaled),
    .divisor_i  (sum),
    .valid_o    (div_valid),
    .quotient_o (div_quo)
  );

  assign quo_s = {1'b0, div_quo[PosW-2:0]};
  assign pos   = zero_q ? '0 : (neg_q ? -quo_s : quo_s);
  assign delta = {pos[PosW-1], pos} - {start_q[PosW-1], start_q};
  assign reach = {1'b0, swipe_distance_q};

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    gesture = GestNone;
    unique case (phase_q)
      PhIdle: begin
        if (touched_q) begin
          phase_d = PhTouched;
          start_d = pos;
          gesture = GestPress;
        end
      end
      PhTouched: begin
        if (!touched_q) begin
          phase_d = PhIdle;
          gesture = GestRelease;
        end else if (delta > reach) begin
          phase_d = PhSwiping;
          gesture = GestForward;
        end else if (delta < -reach) begin
          phase_d = PhSwiping;
          gesture = GestBackward;
        end
      end
      default: begin
        if (!touched_q) begin
          phase_d = PhIdle;
          gesture = GestRelease;
        end
      end
    endcase
  end

  assign emit = (state_q == StHold) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StDiv;
      StDiv:  if (div_valid) state_d = StHold;
      StHold: if (emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_data_d.gesture  = gesture;
      out_data_d.touched  = touched_q;
      out_data_d.position = pos;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      phase_q          <= PhIdle;
      start_q          <= '0;
      out_valid_q      <= 1'b0;
      touch_level_q    <= TouchLevelReset;
      swipe_distance_q <= SwipeDistanceReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        phase_q <= phase_d;
        start_q <= start_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgTouchLevel:    touch_level_q    <= cfg_data_i;
          CfgSwipeDistance: swipe_distance_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      neg_q     <= in_data_i.pad_left > in_data_i.pad_right;
      zero_q    <= (sum == '0);
      touched_q <= (max_all >= touch_level_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- test/tb_touch_strip_swipe_recognizer_core.sv -----
`timescale 1ns / 1ps
module tb_touch_strip_swipe_recognizer_core;
  import tssr_pkg::*;

  localparam int ClkHalf           = 10;
  localparam int ResetCycles       = 5;
  localparam int MaxGap            = 16;
  localparam int SettingCount      = 6;
  localparam int SamplesPerSetting = 155;
  localparam int HoldAfter         = 120;
  localparam int HoldCycles        = 400;
  localparam int QuietCycles       = 20;
  localparam int DrainCycles       = 40;
  localparam int IdleLimit         = 3000;
  localparam int ReportLimit       = 10;

  localparam logic [CfgIdxW-1:0] StrayIndex = '1;

  typedef enum logic [1:0] {
    TrackIdle,
    TrackTouched,
    TrackSwiping
  } track_phase_e;

  class swipe_scoreboard;
    logic [CfgDataW-1:0] touch_level;
    logic [CfgDataW-1:0] swipe_distance;
    track_phase_e        track;
    int                  start_position;
    tssr_out_t           pending_reports[$];
    int                  checked;
    int                  mismatches;
    int                  gesture_count[5];

    function new();
      touch_level    = TouchLevelReset;
      swipe_distance = SwipeDistanceReset;
      track          = TrackIdle;
      start_position = 0;
      checked        = 0;
      mismatches     = 0;
      foreach (gesture_count[g]) gesture_count[g] = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgTouchLevel) begin
        touch_level = val;
      end else if (idx == CfgSwipeDistance) begin
        swipe_distance = val;
      end
    endfunction

    function void note_sample(tssr_in_t s);
      int        l;
      int        m;
      int        r;
      int        total;
      int        pos;
      int        peak;
      int        delta;
      int        reach;
      tssr_out_t e;
      l     = int'(s.pad_left);
      m     = int'(s.pad_middle);
      r     = int'(s.pad_right);
      total = l + m + r;
      pos   = (total == 0) ? 0 : ((r - l) * 100) / total;
      peak  = l;
      if (m > peak) peak = m;
      if (r > peak) peak = r;
      reach      = int'(swipe_distance);
      e.touched  = (peak >= int'(touch_level));
      e.gesture  = GestNone;
      e.position = pos[PosW-1:0];
      case (track)
        TrackIdle: begin
          if (e.touched) begin
            track          = TrackTouched;
            start_position = pos;
            e.gesture      = GestPress;
          end
        end
        TrackTouched: begin
          if (!e.touched) begin
            track     = TrackIdle;
            e.gesture = GestRelease;
          end else begin
            delta = pos - start_position;
            if (delta > reach) begin
              track     = TrackSwiping;
              e.gesture = GestForward;
            end else if (delta < -reach) begin
              track     = TrackSwiping;
              e.gesture = GestBackward;
            end
          end
        end
        default: begin
          if (!e.touched) begin
            track     = TrackIdle;
            e.gesture = GestRelease;
          end
        end
      endcase
      gesture_count[int'(e.gesture)]++;
      pending_reports.push_back(e);
    endfunction

    function void check_result(tssr_out_t got);
      tssr_out_t e;
      checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result %0d arrived with no sample outstanding: gesture %0d touched %0b pos %0d",
                   checked, got.gesture, got.touched, $signed(got.position));
        end
        return;
      end
      e = pending_reports.pop_front();
      if (got.gesture !== e.gesture || got.touched !== e.touched ||
          got.position !== e.position) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result %0d: gesture exp %0d got %0d, touched exp %0b got %0b, pos exp %0d got %0d",
                   checked, e.gesture, got.gesture, e.touched, got.touched,
                   $signed(e.position), $signed(got.position));
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  tssr_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  tssr_out_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  swipe_scoreboard board = new();
  bit              tx_burst = 1'b0;
  int              samples_sent = 0;
  int              settings_run = 0;
  int              quiet_count = 0;

  touch_strip_swipe_recognizer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  function automatic tssr_in_t pads(int l, int m, int r);
    tssr_in_t s;
    s.pad_left   = l[PadW-1:0];
    s.pad_middle = m[PadW-1:0];
    s.pad_right  = r[PadW-1:0];
    return s;
  endfunction

  function automatic tssr_in_t touch_at(int p);
    int mag;
    int big;
    int lesser;
    mag    = (p < 0) ? -p : p;
    big    = int'($urandom_range(int'(board.touch_level), 255));
    lesser = (big * (100 - mag)) / (100 + mag);
    if (p < 0) begin
      return pads(big, int'($urandom_range(0, 12)), lesser);
    end
    return pads(lesser, int'($urandom_range(0, 12)), big);
  endfunction

  function automatic tssr_in_t lifted_sample();
    int top;
    if (board.touch_level == 0) return pads(0, 0, 0);
    top = int'(board.touch_level) - 1;
    return pads(int'($urandom_range(0, top)), int'($urandom_range(0, top)),
                int'($urandom_range(0, top)));
  endfunction

  task automatic send_sample(input tssr_in_t s);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
    samples_sent++;
  endtask

  task automatic run_swipe();
    int p0;
    int p1;
    int steps;
    p0    = int'($urandom_range(0, 200)) - 100;
    p1    = int'($urandom_range(0, 200)) - 100;
    steps = int'($urandom_range(2, 10));
    for (int k = 0; k <= steps; k++) begin
      send_sample(touch_at(p0 + ((p1 - p0) * k) / steps));
    end
    repeat ($urandom_range(1, 2)) send_sample(lifted_sample());
  endtask

  task automatic reg_beat(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, val);
  endtask

  task automatic program_registers(input logic [CfgDataW-1:0] level,
                                   input logic [CfgDataW-1:0] reach, input bit stray);
    reg_beat(CfgTouchLevel, level);
    reg_beat(CfgSwipeDistance, reach);
    if (stray) begin
      reg_beat(StrayIndex, CfgDataW'($urandom_range(0, 255)));
      reg_beat(CfgIdxW'($urandom_range(2, 254)), CfgDataW'($urandom_range(0, 255)));
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    int results;
    bit burst;
    stall_left = 0;
    results    = 0;
    burst      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
        results++;
        stall_left = (results == HoldAfter) ? HoldCycles : draw_gap(burst);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [CfgDataW-1:0] level;
    logic [CfgDataW-1:0] reach;
    int                  mark;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(pads(0, 0, 0));
    send_sample(pads(255, 0, 0));
    send_sample(pads(0, 0, 255));
    send_sample(pads(0, 0, 0));
    send_sample(pads(0, 0, 255));
    send_sample(pads(255, 0, 0));
    send_sample(pads(255, 255, 255));
    send_sample(pads(0, 0, 0));
    send_sample(pads(0, 255, 0));
    send_sample(pads(1, 0, 0));
    send_sample(pads(0, 0, 0));
    send_sample(pads(1, 1, 1));
    send_sample(pads(0, 0, 1));
    send_sample(pads(0, 0, 0));
    send_sample(pads(255, 0, 254));
    send_sample(pads(1, 255, 0));
    send_sample(pads(170, 85, 0));
    send_sample(pads(85, 170, 255));
    send_sample(pads(0, 0, 0));
    send_sample(pads(0, 0, 200));
    send_sample(pads(20, 0, 80));
    send_sample(pads(20, 1, 79));
    send_sample(pads(0, 0, 0));
    drain_results();

    for (int k = 0; k < SettingCount; k++) begin
      case (k)
        0: begin
          level = 8'd255;
          reach = 8'd0;
        end
        1: begin
          level = 8'd0;
          reach = 8'd200;
        end
        2: begin
          level = 8'd1;
          reach = 8'd255;
        end
        3: begin
          level = 8'd128;
          reach = 8'd20;
        end
        default: begin
          level = CfgDataW'($urandom_range(1, 255));
          reach = CfgDataW'($urandom_range(0, 200));
        end
      endcase
      program_registers(level, reach, k == 2);
      mark = samples_sent;
      while (samples_sent - mark < SamplesPerSetting) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(pads(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                           int'($urandom_range(0, 255))));
        end else begin
          run_swipe();
        end
      end
      drain_results();
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d samples and checked %0d results over %0d register settings,",
             samples_sent, board.checked, settings_run);
    $display("with %0d presses, %0d releases, %0d forward and %0d backward swipes predicted.",
             board.gesture_count[GestPress], board.gesture_count[GestRelease],
             board.gesture_count[GestForward], board.gesture_count[GestBackward]);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
